### rtl/fp8m_pkg.sv
// ----------------------------------------------------------------------------
// fp8m_pkg
// Shared types, codes and constants of the FP8 to FP32 multiplier.
// ----------------------------------------------------------------------------
package fp8m_pkg;

  localparam int unsigned FpWidth   = 8;
  localparam int unsigned ResWidth  = 32;
  localparam int unsigned SigWidth  = 4;
  localparam int unsigned ExpWidth  = 7;
  localparam int unsigned AddrWidth = 3;

  localparam logic [ResWidth-1:0] CanonNan = 32'h7FC0_0000;
  localparam logic [ResWidth-1:0] Fp32Inf  = 32'h7F80_0000;

  localparam logic [AddrWidth-1:0] RegFormatAddr = 3'd0;

  typedef enum logic [1:0] {
    ClsZero = 2'd0,
    ClsFin  = 2'd1,
    ClsInf  = 2'd2,
    ClsNan  = 2'd3
  } cls_e;

  typedef struct packed {
    logic                 sign;
    cls_e                 cls;
    logic [SigWidth-1:0]  sig;
    logic signed [ExpWidth-1:0] exp2;
  } dec_t;

  function automatic dec_t decode(input logic [FpWidth-1:0] v, input logic e4m3);
    dec_t d;
    d.sign = v[7];
    d.sig  = '0;
    d.exp2 = '0;
    d.cls  = ClsFin;
    if (e4m3) begin
      if (v[6:3] == 4'hF && v[2:0] == 3'h7) begin
        d.cls = ClsNan;
      end else if (v[6:3] == 4'h0) begin
        d.cls  = (v[2:0] == 3'h0) ? ClsZero : ClsFin;
        d.sig  = {1'b0, v[2:0]};
        d.exp2 = -7'sd9;
      end else begin
        d.sig  = {1'b1, v[2:0]};
        d.exp2 = $signed({3'b000, v[6:3]}) - 7'sd10;
      end
    end else begin
      if (v[6:2] == 5'h1F) begin
        d.cls = (v[1:0] == 2'h0) ? ClsInf : ClsNan;
      end else if (v[6:2] == 5'h00) begin
        d.cls  = (v[1:0] == 2'h0) ? ClsZero : ClsFin;
        d.sig  = {2'b00, v[1:0]};
        d.exp2 = -7'sd16;
      end else begin
        d.sig  = {2'b01, v[1:0]};
        d.exp2 = $signed({2'b00, v[6:2]}) - 7'sd17;
      end
    end
    return d;
  endfunction

endpackage

### rtl/fp8m_core.sv
// ----------------------------------------------------------------------------
// fp8m_core
// Combinational product of two registered operands, as an FP32 pattern.
// ----------------------------------------------------------------------------
module fp8m_core (
  input  logic [fp8m_pkg::FpWidth-1:0]  a_i,
  input  logic [fp8m_pkg::FpWidth-1:0]  b_i,
  input  logic                          e4m3_i,
  output logic [fp8m_pkg::ResWidth-1:0] prod_o
);
  import fp8m_pkg::*;

  dec_t                       da;
  dec_t                       db;
  logic [2*SigWidth-1:0]      sig_prod;
  logic [2:0]                 lead;
  logic signed [8:0]          bexp;
  logic [22:0]                frac;
  logic                       sgn;

  assign da       = decode(a_i, e4m3_i);
  assign db       = decode(b_i, e4m3_i);
  assign sgn      = da.sign ^ db.sign;
  assign sig_prod = {4'b0, da.sig} * {4'b0, db.sig};

  always_comb begin
    lead = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (sig_prod[i]) begin
        lead = 3'(i);
      end
    end
  end

  assign bexp = 9'(signed'({6'b0, lead})) + 9'(da.exp2) + 9'(db.exp2) + 9'sd127;
  assign frac = 23'({15'b0, sig_prod} << (5'd23 - {2'b0, lead}));

  always_comb begin
    if (da.cls == ClsNan || db.cls == ClsNan) begin
      prod_o = CanonNan;
    end else if (da.cls == ClsInf || db.cls == ClsInf) begin
      if (da.cls == ClsZero || db.cls == ClsZero) begin
        prod_o = CanonNan;
      end else begin
        prod_o = {sgn, 31'b0} | Fp32Inf;
      end
    end else if (da.cls == ClsZero || db.cls == ClsZero) begin
      prod_o = {sgn, 31'b0};
    end else begin
      prod_o = {sgn, bexp[7:0], frac};
    end
  end

endmodule

### rtl/fp8_multiply_to_fp32.sv
// ----------------------------------------------------------------------------
// fp8_multiply_to_fp32
// Exact FP8 (E4M3 or E5M2) times FP8 multiplier with an FP32 result stream.
// ----------------------------------------------------------------------------
// The block takes one operand pair per cycle while the skid stage is empty
// and passes it through one input register, the decode and 4x4 significand
// multiply, and an output register with a skid stage so the input keeps
// flowing while one result waits. Register 0 at byte address 0 selects E4M3
// (1) or E5M2 (0) and must only be written while the block is idle.
module fp8_multiply_to_fp32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // operand_a [7:0], operand_b [15:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // product_bits [31:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [fp8m_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fp8m_pkg::*;

  logic        fmt_q;
  logic        in_vld_q;
  logic [15:0] in_q;
  logic        out_vld_q, skid_vld_q;
  logic [31:0] out_q, skid_q;
  logic [31:0] prod;
  logic        in_adv;

  assign pready = 1'b1;
  assign prdata = (paddr == RegFormatAddr) ? {31'b0, fmt_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr == RegFormatAddr) begin
      fmt_q <= pwdata[0];
    end
  end

  fp8m_core u_core (
    .a_i   (in_q[7:0]),
    .b_i   (in_q[15:8]),
    .e4m3_i(fmt_q),
    .prod_o(prod)
  );

  // The input stage moves on whenever the skid stage is free.
  assign s_axis_tready = !skid_vld_q;
  assign in_adv        = !skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q  <= skid_vld_q || (in_adv && in_vld_q);
        skid_vld_q <= 1'b0;
      end else if (in_adv && in_vld_q) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : prod;
    end else if (in_adv && in_vld_q) begin
      skid_q <= prod;
    end
  end

endmodule

### rtl/fp8m_checker.sv
// ----------------------------------------------------------------------------
// fp8m_checker
// Port-level checks of the FP8 multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module fp8m_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        pready
);
  import fp8m_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[30:23] == 8'hFF && m_axis_tdata[22:0] != 23'h0
      |-> m_axis_tdata == CanonNan)
    else $error("non-canonical NaN");

  a_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[30:23] != 8'hFF && m_axis_tdata[30:23] != 8'h0
      |-> m_axis_tdata[30:23] >= 8'd95 && m_axis_tdata[30:23] <= 8'd160)
    else $error("exponent out of FP8 product range");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind fp8_multiply_to_fp32 fp8m_checker u_fp8m_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .pready       (pready)
);

### tb/tb_fp8_multiply_to_fp32.sv
// ----------------------------------------------------------------------------
// tb_fp8_multiply_to_fp32
// Checks the FP8 times FP8 multiplier with an FP32 result stream. A directed
// table of operand pairs covers zeros, NaN, infinity, subnormals and the
// largest values in both formats, then random pairs follow under several
// format settings. Every product is compared with an exact product computed
// inside the testbench, while the stream sides idle at random in most phases.
// ----------------------------------------------------------------------------
module tb_fp8_multiply_to_fp32;
  timeunit 1ns;
  timeprecision 1ps;

  import fp8m_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 8;

  typedef struct {
    logic [7:0]  op_a;
    logic [7:0]  op_b;
    logic        known;
    logic [31:0] product;
  } mul_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        fmt_e4m3;
  logic [31:0] product_q[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          rx_stall_off;

  fp8_multiply_to_fp32 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Splits an FP8 code into class, integer significand and power of two.
  function automatic void split_fp8(input logic [7:0] v, input logic e4m3, output cls_e cls,
                                    output int unsigned sig, output int pow2);
    int unsigned ex;
    int unsigned mt;
    ex = e4m3 ? v[6:3] : v[6:2];
    mt = e4m3 ? v[2:0] : v[1:0];
    sig = 0;
    pow2 = 0;
    cls = ClsFin;
    if (e4m3 && ex == 15 && mt == 7) begin
      cls = ClsNan;
    end else if (!e4m3 && ex == 31) begin
      cls = (mt == 0) ? ClsInf : ClsNan;
    end else if (ex == 0) begin
      cls = (mt == 0) ? ClsZero : ClsFin;
      sig = mt;
      pow2 = e4m3 ? -9 : -16;
    end else begin
      sig = e4m3 ? 8 + mt : 4 + mt;
      pow2 = e4m3 ? int'(ex) - 10 : int'(ex) - 17;
    end
  endfunction

  function automatic logic [31:0] exact_product(logic [7:0] a, logic [7:0] b, logic e4m3);
    cls_e        ca, cb;
    int unsigned sa, sb, prod, msb;
    int          pa, pb;
    logic [31:0] sgn;
    logic [31:0] frac;
    split_fp8(a, e4m3, ca, sa, pa);
    split_fp8(b, e4m3, cb, sb, pb);
    sgn = {a[7] ^ b[7], 31'd0};
    if (ca == ClsNan || cb == ClsNan) return CanonNan;
    if (ca == ClsInf || cb == ClsInf) begin
      if (ca == ClsZero || cb == ClsZero) return CanonNan;
      return sgn | Fp32Inf;
    end
    if (ca == ClsZero || cb == ClsZero) return sgn;
    prod = sa * sb;
    msb = 0;
    for (int i = 7; i >= 0; i--) begin
      if (prod[i] && msb == 0) msb = i;
    end
    frac = (prod << (23 - msb)) & 32'h007F_FFFF;
    return sgn | (32'(msb + pa + pb + 127) << 23) | frac;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h", what, got, want);
    error_count++;
  endtask

  task automatic write_format(input logic e4m3);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegFormatAddr;
    pwdata <= {31'd0, e4m3};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fmt_e4m3 = e4m3;
  endtask

  task automatic wait_idle();
    while (product_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    product_q.push_back(exact_product(a, b, fmt_e4m3));
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned count, input bit gaps);
    logic [7:0] a, b;
    for (int unsigned i = 0; i < count; i++) begin
      a = 8'($urandom);
      b = 8'($urandom);
      if ($urandom_range(0, 9) == 0) a[6:0] = $urandom_range(0, 1) ? 7'h7F : 7'h00;
      if ($urandom_range(0, 9) == 0) b[6:0] = 7'($urandom_range(0, 3) << 5) | 7'h1F;
      send_pair(a, b, gaps);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (product_q.size() == 0) begin
        report_mismatch("unexpected product", m_axis_tdata, 32'd0);
      end else begin
        if (m_axis_tdata !== product_q[0])
          report_mismatch("product_bits", m_axis_tdata, product_q[0]);
        void'(product_q.pop_front());
      end
    end
  end

  initial begin
    int unsigned g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_stall_off || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        g = 1 + gap_len();
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[fp8_multiply_to_fp32] ERROR");
      $finish;
    end
  end

  mul_row_t rows[] = '{
    '{8'h00, 8'h00, 1'b1, 32'h0000_0000},
    '{8'h80, 8'h00, 1'b1, 32'h8000_0000},
    '{8'h80, 8'h80, 1'b1, 32'h0000_0000},
    '{8'h7F, 8'h38, 1'b1, CanonNan},
    '{8'hFF, 8'h00, 1'b1, CanonNan},
    '{8'h38, 8'h38, 1'b1, 32'h3F80_0000},
    '{8'h7E, 8'h7E, 1'b0, 32'h0},
    '{8'h01, 8'h01, 1'b0, 32'h0},
    '{8'h7E, 8'h81, 1'b0, 32'h0},
    '{8'h77, 8'h07, 1'b0, 32'h0},
    '{8'hAA, 8'h55, 1'b0, 32'h0}
  };

  mul_row_t e5_rows[] = '{
    '{8'h7C, 8'h00, 1'b1, CanonNan},
    '{8'h7C, 8'h3C, 1'b1, 32'h7F80_0000},
    '{8'hFC, 8'h7C, 1'b1, 32'hFF80_0000},
    '{8'h7D, 8'h3C, 1'b1, CanonNan},
    '{8'h7F, 8'hFF, 1'b1, CanonNan},
    '{8'h3C, 8'h3C, 1'b1, 32'h3F80_0000},
    '{8'h80, 8'h3C, 1'b1, 32'h8000_0000},
    '{8'h7B, 8'h7B, 1'b0, 32'h0},
    '{8'h01, 8'h01, 1'b0, 32'h0},
    '{8'h03, 8'hFB, 1'b0, 32'h0},
    '{8'hFC, 8'h01, 1'b0, 32'h0}
  };

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fmt_e4m3 = 1'b1;
    error_count = 0;
    idle_cycles = 0;
    rx_stall_off = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      send_pair(rows[i].op_a, rows[i].op_b, 1'b1);
      if (rows[i].known && product_q[$] !== rows[i].product)
        report_mismatch("table row", product_q[$], rows[i].product);
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();
    write_format(1'b0);
    foreach (e5_rows[i]) begin
      send_pair(e5_rows[i].op_a, e5_rows[i].op_b, 1'b0);
      if (e5_rows[i].known && product_q[$] !== e5_rows[i].product)
        report_mismatch("table row", product_q[$], e5_rows[i].product);
    end
    s_axis_tvalid <= 1'b0;

    run_random(300, 1'b1);
    wait_idle();
    write_format(1'b1);
    run_random(300, 1'b1);
    wait_idle();
    write_format(1'b0);
    rx_stall_off = 1'b1;
    run_random(150, 1'b0);
    rx_stall_off = 1'b0;
    wait_idle();
    write_format(1'b1);
    run_random(380, 1'b1);
    wait_idle();

    if (error_count == 0 && product_q.size() == 0) begin
      $display("[fp8_multiply_to_fp32] OK");
    end else begin
      $display("[fp8_multiply_to_fp32] ERROR");
    end
    $finish;
  end

endmodule
